// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/adsr_pkg.sv
// Types and constants of the ADC SPI frame responder.
`default_nettype none

package adsr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CHAN_W     = 2;
    localparam int unsigned CODE_W     = 6;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned REPLY_LEN  = 7;
    localparam int unsigned NUM_CHAN   = 4;

    localparam logic [POS_W-1:0] POS_LAST = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAM_READ_CODE = 3'd0,
        CFG_ADDR_A        = 3'd1,
        CFG_ADDR_B        = 3'd2,
        CFG_ADDR_C        = 3'd3,
        CFG_ADDR_D        = 3'd4
    } t_cfg_index;

    typedef enum logic {
        REQ_SPI_BYTE = 1'b0,
        REQ_SAMPLE   = 1'b1
    } t_req_type;

    typedef struct packed {
        logic                       req_type;
        logic [BYTE_W-1:0]          mosi_byte;
        logic [CHAN_W-1:0]          sample_channel;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] miso_byte;
        logic              frame_end;
    } t_out_item;

    // Classified request as it travels from front to back.
    typedef struct packed {
        logic                 is_sample;
        logic [CHAN_W-1:0]    channel;
        logic [SAMPLE_W-1:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [CODE_W-1:0] ram_read_code;
        logic [BYTE_W-1:0] addr_a;
        logic [BYTE_W-1:0] addr_b;
        logic [BYTE_W-1:0] addr_c;
        logic [BYTE_W-1:0] addr_d;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// File: rtl/core/adsr_front.sv
// Front end: accepts requests, classifies them and hands them to the queue.
`default_nettype none

module adsr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire adsr_pkg::t_in_item i_in_data,
    input  wire adsr_pkg::t_q_status i_q_status,
    output logic                   o_push,
    output adsr_pkg::t_cmd         o_cmd
);
    import adsr_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign o_push     = r_valid && !i_q_status.full;
    assign o_in_stall = r_valid && i_q_status.full;
    assign take       = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.is_sample = (i_in_data.req_type == REQ_SAMPLE);
        n_cmd.channel   = i_in_data.sample_channel;
        if (i_in_data.req_type == REQ_SAMPLE) begin
            n_cmd.data = $unsigned(i_in_data.sample_value);
        end else begin
            n_cmd.data = {{(SAMPLE_W-BYTE_W){1'b0}}, i_in_data.mosi_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/adsr_queue.sv
// Short request queue between front and back.
`default_nettype none

module adsr_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire adsr_pkg::t_cmd    i_cmd,
    input  wire logic              i_pop,
    output adsr_pkg::t_cmd         o_head,
    output adsr_pkg::t_q_status    o_status
);
    import adsr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/adsr_back.sv
// Back end: frame state, reply bytes, channel samples and the output register.
`default_nettype none

module adsr_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [adsr_pkg::BYTE_W-1:0]    i_cfg_data,
    input  wire adsr_pkg::t_cmd      i_head,
    input  wire adsr_pkg::t_q_status i_q_status,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output adsr_pkg::t_out_item      o_out_data
);
    import adsr_pkg::*;

    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    t_cfg                r_cfg;
    logic [POS_W-1:0]    r_pos;
    logic [BYTE_W-1:0]   r_hdr   [2];
    logic [BYTE_W-1:0]   r_reply [REPLY_LEN];
    logic [SAMPLE_W-1:0] r_smp   [NUM_CHAN];
    logic                r_out_valid;
    t_out_item           r_out;

    logic [2*BYTE_W-1:0] hdr;
    logic [CODE_W-1:0]   code;
    logic [BYTE_W-1:0]   addr;
    logic                code_hit;
    logic                addr_hit;
    logic [CHAN_W-1:0]   sel_ch;
    logic [SAMPLE_W-1:0] sel_smp;
    logic [BYTE_W-1:0]   n_reply [REPLY_LEN];
    logic [BYTE_W-1:0]   sum;
    logic                byte_pop;

    assign o_pop = i_q_status.valid
                   && (i_head.is_sample || !r_out_valid || !i_out_stall);
    assign byte_pop    = o_pop && !i_head.is_sample;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Reply built at the close of a frame.
    always_comb begin
        hdr      = {r_hdr[1], r_hdr[0]};
        code     = hdr[6:1];
        addr     = hdr[14:7];
        code_hit = (code == r_cfg.ram_read_code);
        addr_hit = 1'b1;
        if (addr == r_cfg.addr_a) begin
            sel_ch = 2'd1;
        end else if (addr == r_cfg.addr_b) begin
            sel_ch = 2'd2;
        end else if (addr == r_cfg.addr_c) begin
            sel_ch = 2'd3;
        end else if (addr == r_cfg.addr_d) begin
            sel_ch = 2'd0;
        end else begin
            sel_ch   = 2'd0;
            addr_hit = 1'b0;
        end
        sel_smp = r_smp[sel_ch];
        for (int i = 0; i < REPLY_LEN; i++) begin
            n_reply[i] = r_reply[i];
        end
        n_reply[0] = r_hdr[0];
        n_reply[1] = r_hdr[1];
        if (addr_hit) begin
            n_reply[2] = sel_smp[BYTE_W-1:0];
            n_reply[3] = sel_smp[SAMPLE_W-1:BYTE_W];
            n_reply[4] = sel_smp[BYTE_W-1:0];
            n_reply[5] = sel_smp[SAMPLE_W-1:BYTE_W];
        end
        sum = '0;
        for (int i = 0; i < REPLY_LEN - 1; i++) begin
            sum = sum + n_reply[i];
        end
        n_reply[REPLY_LEN-1] = ~sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_read_code <= '0;
            r_cfg.addr_a        <= 8'd0;
            r_cfg.addr_b        <= 8'd1;
            r_cfg.addr_c        <= 8'd2;
            r_cfg.addr_d        <= 8'd3;
            r_pos               <= '0;
            r_hdr[0]            <= '0;
            r_hdr[1]            <= '0;
            for (int i = 0; i < REPLY_LEN; i++) begin
                r_reply[i] <= '0;
            end
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_smp[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RAM_READ_CODE: r_cfg.ram_read_code <= i_cfg_data[CODE_W-1:0];
                    CFG_ADDR_A:        r_cfg.addr_a        <= i_cfg_data;
                    CFG_ADDR_B:        r_cfg.addr_b        <= i_cfg_data;
                    CFG_ADDR_C:        r_cfg.addr_c        <= i_cfg_data;
                    CFG_ADDR_D:        r_cfg.addr_d        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_pop && i_head.is_sample) begin
                r_smp[i_head.channel] <= i_head.data;
            end
            if (byte_pop) begin
                if (r_pos < 3'd2) begin
                    r_hdr[r_pos[0]] <= i_head.data[BYTE_W-1:0];
                end
                if (r_pos == POS_LAST) begin
                    r_pos <= '0;
                    if (code_hit) begin
                        for (int i = 0; i < REPLY_LEN; i++) begin
                            r_reply[i] <= n_reply[i];
                        end
                    end
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (byte_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_pop) begin
            r_out.miso_byte <= flip8(r_reply[r_pos]);
            r_out.frame_end <= (r_pos == POS_LAST);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/adc_spi_frame_responder.sv
// Top level of the ADC SPI frame responder.
//
//  channel  dir  handshake                 payload
//  in       rx   i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out      tx   o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg      rx   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the queue has room; a reply byte
// follows its request through front register, queue slot, output register.
// The frame close (header decode, sample select, six-byte checksum) fits in the
// same cycle as the last byte; on a code hit the next frame sees the new reply.
// Reset is synchronous, active low; all frame state and samples clear to zero.
// A stalled output holds byte requests; the queue lets the front keep accepting.
`default_nettype none

module adc_spi_frame_responder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire adsr_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output adsr_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [adsr_pkg::BYTE_W-1:0]     i_cfg_data
);
    import adsr_pkg::*;

    `include "assert_macros.svh"

    t_cmd      front_cmd;
    t_cmd      q_head;
    t_q_status q_status;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    adsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    adsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    adsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (q_head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `ASSERT_IMPLIES(a_no_overflow, push, !q_status.full, "push into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, pop, q_status.valid, "pop from an empty queue")
    `ASSERT_IMPLIES(a_no_overwrite, o_out_valid && i_out_stall, !(pop && !q_head.is_sample),
        "reply byte issued over a stalled result")

endmodule

`default_nettype wire
